/* sv/top_n_stream_id_rate_tracker_macros.svh */
// Assertion macros used by the checker file of the rate tracker.
`ifndef TOP_N_STREAM_ID_RATE_TRACKER_MACROS_SVH
`define TOP_N_STREAM_ID_RATE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSIRT_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nsirt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NSIRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nsirt assertion failed");

`endif

/* sv/nsirt_pkg.sv */
// Shared types and constants of the stream rate tracker.
package nsirt_pkg;

  localparam int ID_W    = 13;
  localparam int PAY_W   = 16;
  localparam int ELAP_W  = 32;
  localparam int CNT_W   = 48;
  localparam int RATE_W  = 32;
  localparam int SLOT_W  = 3;
  localparam int MAX_OUT = 8;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  dividend;
    logic [ELAP_W-1:0] divisor;
  } div_req_t;

endpackage

/* sv/top_n_stream_id_rate_tracker.sv */
// Top level of the top-N stream rate tracker with its sequencer.
// Usage:
//   Input stream: tuser carries the kind (add or report), tdata the stream id,
//   payload bytes and elapsed milliseconds. One transfer is one item.
//   Output stream: on a report, one transfer per occupied slot up to MAX_OUT,
//   in rank order, tlast on the final one; an empty table yields one marker
//   with tuser low. Config channel: cfg_data_i bit 0 selects bytes (1) or
//   bits (0); it is always ready, and the user writes it only while the
//   block is idle; the block itself does not enforce this.
//   An add is a scan of the occupied slots through one id compare, then one
//   slot move per cycle through one count compare, each bound by the single
//   table memory port. A report takes, per result, a table read, the
//   one-bit-per-cycle divider (48 steps and its done flag) and an output
//   step; elapsed 0 skips the divider.
//   s_axis_tready is high only while the sequencer is idle; a result waiting
//   in the output register does not block the next item, but a report stalls
//   while the receiver holds m_axis_tready low.
//   Reset empties the table through the fill count and sets byte mode.
module top_n_stream_id_rate_tracker #(
  parameter int SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] stream_id, [28:13] payload_bytes, [60:29] elapsed_ms, [63:61] zero
  input  logic [63:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] slot, [15:3] stream_id_out, [47:16] rate
  output logic [47:0] m_axis_tdata,
  // [0] active
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import nsirt_pkg::*;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_BUBBLE    = 3'd2;
  localparam logic [2:0] ST_WRITE     = 3'd3;
  localparam logic [2:0] ST_REP_LOAD  = 3'd4;
  localparam logic [2:0] ST_REP_DIV   = 3'd5;
  localparam logic [2:0] ST_REP_OUT   = 3'd6;
  localparam logic [2:0] ST_REP_EMPTY = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  ra_q, ra_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  entry_t            hold_q, hold_d;
  logic [ID_W-1:0]   rep_id_q, rep_id_d;
  logic              rate_in_bytes_q;

  logic [ID_W-1:0]   item_id_q;
  logic [PAY_W-1:0]  item_pay_q;
  logic [ELAP_W-1:0] item_elap_q;

  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [RATE_W-1:0] out_rate_q, out_rate_d;
  logic              out_active_q, out_active_d;
  logic              out_last_q, out_last_d;
  logic              out_load, out_free;

  logic              accept;
  logic              in_kind;
  logic [ID_W-1:0]   in_id;
  logic [PAY_W-1:0]  in_pay;
  logic [ELAP_W-1:0] in_elap;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  entry_t            rd;

  div_req_t          div_req;
  logic              div_done;
  logic [CNT_W-1:0]  div_quot;
  logic [CNT_W+9:0]  prod;
  logic [CNT_W-1:0]  quot;
  logic [RATE_W-1:0] rate;

  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  sat_cnt;
  logic              full;
  logic              scan_end;
  logic [CNT_W-1:0]  last_cnt;
  logic              rep_last;
  logic [IDX_W-1:0]  ins_pos;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_kind       = s_axis_tuser;
  assign in_id         = s_axis_tdata[12:0];
  assign in_pay        = s_axis_tdata[28:13];
  assign in_elap       = s_axis_tdata[60:29];
  assign cfg_ready_o   = 1'b1;

  nsirt_table_mem #(.DEPTH(SLOTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ra_d),
    .rdata_o (rd)
  );

  nsirt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    sum      = {1'b0, rd.count} + (CNT_W + 1)'(item_pay_q);
    sat_cnt  = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
    full     = (fill_q == FILL_W'(SLOTS));
    scan_end = ((FILL_W'(ra_q) + FILL_W'(1)) == fill_q);
    last_cnt = full ? rd.count : '0;
    rep_last = ((FILL_W'(ra_q) + FILL_W'(1)) == fill_q) || (int'(ra_q) == MAX_OUT - 1);
    ins_pos  = full ? IDX_W'(SLOTS - 1) : IDX_W'(fill_q);
    prod     = {rd.count, 10'b0} - ((CNT_W + 10)'(rd.count) << 4)
               - ((CNT_W + 10)'(rd.count) << 3);
    quot     = (item_elap_q == '0) ? '0 : div_quot;
    if (rate_in_bytes_q) begin
      rate = (quot > CNT_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
    end else begin
      rate = (quot > CNT_W'(RATE_MAX >> 3)) ? RATE_MAX : {quot[RATE_W-4:0], 3'b000};
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d          = state_q;
    fill_d           = fill_q;
    ra_d             = ra_q;
    pos_d            = pos_q;
    hold_d           = hold_q;
    rep_id_d         = rep_id_q;
    mem_we           = 1'b0;
    mem_waddr        = pos_q;
    mem_wdata        = hold_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod[CNT_W+9:10];
    div_req.divisor  = item_elap_q;
    out_load         = 1'b0;
    out_slot_d       = SLOT_W'(ra_q);
    out_id_d         = rep_id_q;
    out_rate_d       = rate;
    out_active_d     = 1'b1;
    out_last_d       = rep_last;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_REPORT) begin
            if (fill_q == '0) begin
              state_d = ST_REP_EMPTY;
            end else begin
              ra_d    = '0;
              state_d = ST_REP_LOAD;
            end
          end else if (fill_q == '0) begin
            if (in_pay != '0) begin
              hold_d  = '{id: in_id, count: CNT_W'(in_pay)};
              pos_d   = '0;
              fill_d  = FILL_W'(1);
              state_d = ST_WRITE;
            end
          end else begin
            ra_d    = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd.id == item_id_q) begin
          hold_d = '{id: item_id_q, count: sat_cnt};
          pos_d  = ra_q;
          if (ra_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            ra_d    = ra_q - IDX_W'(1);
            state_d = ST_BUBBLE;
          end
        end else if (scan_end) begin
          if (CNT_W'(item_pay_q) > last_cnt) begin
            hold_d = '{id: item_id_q, count: CNT_W'(item_pay_q)};
            pos_d  = ins_pos;
            if (!full) begin
              fill_d = fill_q + FILL_W'(1);
            end
            if (ins_pos == '0) begin
              state_d = ST_WRITE;
            end else begin
              ra_d    = ins_pos - IDX_W'(1);
              state_d = ST_BUBBLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          ra_d = ra_q + IDX_W'(1);
        end
      end
      ST_BUBBLE: begin
        if (rd.count < hold_q.count) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = rd;
          pos_d     = pos_q - IDX_W'(1);
          if (pos_q == IDX_W'(1)) begin
            state_d = ST_WRITE;
          end else begin
            ra_d = pos_q - IDX_W'(2);
          end
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_REP_LOAD: begin
        rep_id_d = rd.id;
        if (item_elap_q == '0) begin
          state_d = ST_REP_OUT;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_REP_DIV;
        end
      end
      ST_REP_DIV: begin
        if (div_done) begin
          state_d = ST_REP_OUT;
        end
      end
      ST_REP_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rep_last) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            ra_d    = ra_q + IDX_W'(1);
            state_d = ST_REP_LOAD;
          end
        end
      end
      ST_REP_EMPTY: begin
        out_slot_d   = '0;
        out_id_d     = '0;
        out_rate_d   = '0;
        out_active_d = 1'b0;
        out_last_d   = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      fill_q          <= '0;
      ra_q            <= '0;
      out_valid_q     <= 1'b0;
      rate_in_bytes_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ra_q        <= ra_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        rate_in_bytes_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    hold_q   <= hold_d;
    rep_id_q <= rep_id_d;
    if (accept) begin
      item_id_q   <= in_id;
      item_pay_q  <= in_pay;
      item_elap_q <= in_elap;
    end
    if (out_load) begin
      out_slot_q   <= out_slot_d;
      out_id_q     <= out_id_d;
      out_rate_q   <= out_rate_d;
      out_active_q <= out_active_d;
      out_last_q   <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rate_q, out_id_q, out_slot_q};
  assign m_axis_tuser  = out_active_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* sv/nsirt_table_mem.sv */
// Slot table storage: one write port, one registered read port.
module nsirt_table_mem #(
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  nsirt_pkg::entry_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output nsirt_pkg::entry_t rdata_o
);
  import nsirt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/nsirt_divider.sv */
// Restoring divider, one quotient bit per cycle.
module nsirt_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nsirt_pkg::div_req_t           req_i,
  output logic                          done_o,
  output logic [nsirt_pkg::CNT_W-1:0]   quot_o
);
  import nsirt_pkg::*;

  localparam int CW = $clog2(CNT_W + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  q_q, q_d;
  logic [ELAP_W-1:0] rem_q, rem_d;
  logic [ELAP_W-1:0] dvs_q, dvs_d;
  logic [ELAP_W:0]   partial;
  logic              ge;

  always_comb begin
    partial = {rem_q, q_q[CNT_W-1]};
    ge      = partial >= {1'b0, dvs_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    q_d     = q_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      q_d   = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = CW'(CNT_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? ELAP_W'(partial - {1'b0, dvs_q}) : partial[ELAP_W-1:0];
      q_d    = {q_q[CNT_W-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

/* sv/nsirt_checker.sv */
// Port-level checker for the rate tracker and its bind.
`include "top_n_stream_id_rate_tracker_macros.svh"

module nsirt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  `NSIRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `NSIRT_ASSERT_NOW(a_marker_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
  `NSIRT_ASSERT_NOW(a_marker_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 48'd0)

endmodule

bind top_n_stream_id_rate_tracker nsirt_checker u_nsirt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* bench/testbench.sv */
// Testbench of the top-N stream rate tracker: directed rows and random traffic vs. a table model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsirt_pkg::*;

  localparam int SLOTS          = 8;
  localparam int SETTLE_CYCLES  = 4 * SLOTS + 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEGMENTS       = 4;
  localparam int SEGMENT_ITEMS  = 80;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [RATE_W-1:0] rate;
    logic              active;
    logic              last;
  } rate_report_t;

  typedef struct {
    bit                is_cfg;
    logic              cfg_val;
    logic              kind;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  pay;
    logic [ELAP_W-1:0] el;
    int                reps;
    bit                typed;
    rate_report_t      res;
  } stim_row_t;

  localparam rate_report_t EMPTY_MARK = '{slot: '0, id: '0, rate: '0, active: 1'b0, last: 1'b1};
  localparam rate_report_t NO_RES     = '0;

  stim_row_t directed_rows [29] = '{
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'd5, 1, 1'b1, EMPTY_MARK},
    '{1'b0, 1'b0, KIND_ADD,    13'd8191, 16'd65535, 32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'd0, 1, 1'b1,
      '{3'd0, 13'd8191, 32'd0, 1'b1, 1'b1}},
    '{1'b0, 1'b0, KIND_ADD,    13'd0,    16'd0,     32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'd1, 1, 1'b1, EMPTY_MARK},
    '{1'b0, 1'b0, KIND_ADD,    13'd0,    16'd1,     32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd0,    16'd65535, 32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'd1, 1, 1'b1,
      '{3'd0, 13'd0, 32'd64000, 1'b1, 1'b1}},
    '{1'b0, 1'b0, KIND_ADD,    13'd100,  16'd300,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd101,  16'd300,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd102,  16'd500,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd103,  16'd200,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd104,  16'd300,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd105,  16'd700,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd106,  16'd100,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd107,  16'd50,    32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd108,  16'd50,    32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd109,  16'd51,    32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd101,  16'd400,   32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'd1, 1, 1'b0, NO_RES},
    '{1'b1, 1'b0, KIND_ADD,    13'd0,    16'd0,     32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd4660, 16'd65535, 32'd0, 20, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'd1, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd5,    16'd12345, 32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd6,    16'd65535, 32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'hFFFF_FFFF, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_ADD,    13'd7,    16'd40000, 32'd0, 1, 1'b0, NO_RES},
    '{1'b0, 1'b0, KIND_REPORT, 13'd0,    16'd0,     32'd3, 1, 1'b0, NO_RES},
    '{1'b1, 1'b1, KIND_ADD,    13'd0,    16'd0,     32'd0, 1, 1'b0, NO_RES}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;

  logic [ID_W-1:0]  slot_id  [SLOTS];
  logic             slot_occ [SLOTS];
  logic [CNT_W-1:0] slot_cnt [SLOTS];
  logic             bytes_unit = 1'b1;

  rate_report_t expected_reports [$];
  int           fail_count  = 0;
  int           quiet_cycles = 0;
  int           stall_left  = 0;
  bit           calm        = 1'b0;
  logic [ID_W-1:0] id_pool [12];

  top_n_stream_id_rate_tracker #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  function automatic void clear_slots();
    for (int i = 0; i < SLOTS; i++) begin
      slot_id[i]  = '0;
      slot_occ[i] = 1'b0;
      slot_cnt[i] = '0;
    end
  endfunction

  // stable insertion sort, descending by count
  function automatic void sort_slots();
    logic [ID_W-1:0]  t_id;
    logic             t_occ;
    logic [CNT_W-1:0] t_cnt;
    int               j;
    for (int i = 1; i < SLOTS; i++) begin
      t_id  = slot_id[i];
      t_occ = slot_occ[i];
      t_cnt = slot_cnt[i];
      j = i;
      while (j > 0 && slot_cnt[j-1] < t_cnt) begin
        slot_id[j]  = slot_id[j-1];
        slot_occ[j] = slot_occ[j-1];
        slot_cnt[j] = slot_cnt[j-1];
        j--;
      end
      slot_id[j]  = t_id;
      slot_occ[j] = t_occ;
      slot_cnt[j] = t_cnt;
    end
  endfunction

  function automatic logic [RATE_W-1:0] slot_rate(logic [CNT_W-1:0] cnt, logic [ELAP_W-1:0] el);
    logic [63:0] q;
    if (el == '0) return '0;
    q = ({16'd0, cnt} * 64'd1000) / ({32'd0, el} * 64'd1024);
    if (!bytes_unit) begin
      if (q > {32'd0, RATE_MAX} / 64'd8) return RATE_MAX;
      q = q * 64'd8;
    end
    if (q > {32'd0, RATE_MAX}) return RATE_MAX;
    return q[RATE_W-1:0];
  endfunction

  function automatic void track_item(logic kind, logic [ID_W-1:0] sid, logic [PAY_W-1:0] pay,
                                     logic [ELAP_W-1:0] el, bit record);
    logic [CNT_W:0] sum;
    bit             hit;
    bit             pending;
    rate_report_t   held;
    hit     = 1'b0;
    pending = 1'b0;
    held    = EMPTY_MARK;
    if (kind == KIND_ADD) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit && slot_occ[i] && slot_id[i] == sid) begin
          sum = {1'b0, slot_cnt[i]} + {{(CNT_W-PAY_W+1){1'b0}}, pay};
          slot_cnt[i] = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[CNT_W-1:0];
          hit = 1'b1;
        end
      end
      if (hit) begin
        sort_slots();
      end else if (slot_cnt[SLOTS-1] < {{(CNT_W-PAY_W){1'b0}}, pay}) begin
        slot_id[SLOTS-1]  = sid;
        slot_occ[SLOTS-1] = 1'b1;
        slot_cnt[SLOTS-1] = {{(CNT_W-PAY_W){1'b0}}, pay};
        sort_slots();
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_occ[i]) begin
          if (pending && record) expected_reports.push_back(held);
          held.slot   = SLOT_W'(i);
          held.id     = slot_id[i];
          held.rate   = slot_rate(slot_cnt[i], el);
          held.active = 1'b1;
          held.last   = 1'b0;
          pending     = 1'b1;
        end
      end
      held.last = 1'b1;
      if (record) expected_reports.push_back(held);
      clear_slots();
    end
  endfunction

  task automatic send_item(input logic kind, input logic [ID_W-1:0] sid,
                           input logic [PAY_W-1:0] pay, input logic [ELAP_W-1:0] el,
                           input bit record);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, el, pay, sid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_item(kind, sid, pay, el, record);
  endtask

  // drain pending results, then let any add in flight finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate_unit(input logic bytes_mode);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= bytes_mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    bytes_unit = bytes_mode;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (!calm && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 5);
    m_axis_tready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin : check_results
    rate_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $error("output transfer with no result pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("slot", 32'(want.slot), 32'(m_axis_tdata[2:0]));
        check_field("stream_id_out", 32'(want.id), 32'(m_axis_tdata[15:3]));
        check_field("rate", want.rate, m_axis_tdata[47:16]);
        check_field("active", 32'(want.active), 32'(m_axis_tuser));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int                seg;
    int                pick;
    logic              kind;
    logic [ID_W-1:0]   sid;
    logic [PAY_W-1:0]  pay;
    logic [ELAP_W-1:0] el;
    clear_slots();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        settle();
        write_rate_unit(directed_rows[r].cfg_val);
      end else begin
        repeat (directed_rows[r].reps) begin
          send_item(directed_rows[r].kind, directed_rows[r].id, directed_rows[r].pay,
                    directed_rows[r].el, !directed_rows[r].typed);
        end
        if (directed_rows[r].typed) expected_reports.push_back(directed_rows[r].res);
      end
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      if (seg == 2) write_rate_unit(1'($urandom_range(0, 1)));
      else write_rate_unit(seg[0]);
      calm = (seg == 1 || seg == SEGMENTS - 1);
      foreach (id_pool[p]) id_pool[p] = ID_W'($urandom_range(0, 8191));
      repeat (SEGMENT_ITEMS) begin
        kind = ($urandom_range(0, 99) < 12) ? KIND_REPORT : KIND_ADD;
        if ($urandom_range(0, 9) < 7) sid = id_pool[$urandom_range(0, 11)];
        else sid = ID_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) pay = '0;
        else if (pick < 20) pay = '1;
        else if (pick < 40) pay = PAY_W'(100 * $urandom_range(1, 3));
        else pay = PAY_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15) el = '0;
        else if (pick < 30) el = 32'd1;
        else if (pick < 70) el = $urandom_range(2, 50);
        else if (pick < 85) el = $urandom;
        else el = '1;
        send_item(kind, sid, pay, el, 1'b1);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* top_n_stream_id_rate_tracker.f */
+incdir+sv
sv/nsirt_pkg.sv
sv/nsirt_table_mem.sv
sv/nsirt_divider.sv
sv/top_n_stream_id_rate_tracker.sv
sv/nsirt_checker.sv
bench/testbench.sv
